>>> hw/rtl/sal_pkg.sv
package sal_pkg;

    localparam int MAX_SETS   = 4096;
    localparam int MAX_WAYS   = 16;
    localparam int ADDR_WIDTH = 32;
    localparam int SET_W      = $clog2(MAX_SETS);
    localparam int WAY_W      = $clog2(MAX_WAYS);
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 5;

    localparam logic [2:0] ACC_FLUSH = 3'd4;

    localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

    typedef struct packed {
        logic                  valid;
        logic [ADDR_WIDTH-1:0] tag;
    } way_t;

    typedef way_t [MAX_WAYS-1:0] row_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic clear_row;
        logic flush_done;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
    } status_t;

endpackage

>>> hw/rtl/set_assoc_lru_cache_lookup.sv
// Tag-only set-associative cache lookup with true LRU. A lookup (types other
// than flush) first reads the whole set row from the tag memory at the
// transfer edge; then, with busy high, the row is compared and the reordered
// row written back; done strobes for one cycle in the next, with hit and
// hit_count, and a new transfer may be taken in that same cycle.
// A flush walks all 4096 set rows, one per cycle, and strobes done after the
// last (hit 0, hit_count unchanged). After reset the same clearing pass over
// all rows runs with busy high; configuration writes are taken at any time but
// must only change while the block is idle. Results cannot be held off.
module set_assoc_lru_cache_lookup
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [sal_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        access_type,
    input  logic [sal_pkg::ADDR_WIDTH-1:0]    address,
    output logic                              done,
    output logic                              hit,
    output logic [sal_pkg::CNT_W-1:0]         hit_count
);

    sal_pkg::cmd_t    cmd;
    sal_pkg::status_t status;

    sal_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .access_type (access_type),
        .status      (status),
        .cmd         (cmd),
        .busy        (busy)
    );

    sal_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .address   (address),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .hit       (hit),
        .hit_count (hit_count)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    a_lookup_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (access_type != sal_pkg::ACC_FLUSH)) |=> ##1 done)
        else $error("lookup result missing");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (hit_count != '0))
        else $error("hit with zero count");

endmodule

>>> hw/rtl/sal_ctrl.sv
module sal_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2:0]       access_type,
    input  sal_pkg::status_t status,
    output sal_pkg::cmd_t    cmd,
    output logic             busy
);

    sal_pkg::state_t state_reg;
    sal_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sal_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            sal_pkg::ST_CLEAR:
            begin
                cmd.clear_row = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = sal_pkg::ST_IDLE;
                end
            end
            sal_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (access_type == sal_pkg::ACC_FLUSH)
                    begin
                        state_next = sal_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = sal_pkg::ST_LOOKUP;
                    end
                end
            end
            sal_pkg::ST_LOOKUP:
            begin
                cmd.update = 1'b1;
                state_next = sal_pkg::ST_IDLE;
            end
            sal_pkg::ST_FLUSH:
            begin
                cmd.clear_row = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.flush_done = 1'b1;
                    state_next     = sal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sal_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/sal_dp.sv
module sal_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [sal_pkg::CFG_W-1:0]          cfg_data,
    input  logic [sal_pkg::ADDR_WIDTH-1:0]     address,
    input  sal_pkg::cmd_t                      cmd,
    output sal_pkg::status_t                   status,
    output logic                               done,
    output logic                               hit,
    output logic [sal_pkg::CNT_W-1:0]          hit_count
);

    logic [4:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [4:0] ways_in_use_reg;

    sal_pkg::row_t mem [sal_pkg::MAX_SETS];
    sal_pkg::row_t rdata_reg;

    logic [sal_pkg::SET_W-1:0]      set_reg;
    logic [sal_pkg::ADDR_WIDTH-1:0] tag_reg;
    logic [sal_pkg::SET_W-1:0]      sweep_reg;
    logic [sal_pkg::CNT_W-1:0]      count_reg;
    logic                           done_reg;
    logic                           hit_reg;

    logic [sal_pkg::ADDR_WIDTH-1:0] shifted;
    logic [5:0]                     tag_shift;
    logic [15:0]                    imask;
    logic [sal_pkg::SET_W-1:0]      set_in;
    logic [sal_pkg::ADDR_WIDTH-1:0] tag_in;

    logic [4:0]                     ways_k;
    logic [sal_pkg::MAX_WAYS-1:0]   match;
    logic                           hit_now;
    logic [sal_pkg::WAY_W-1:0]      pos;
    logic [sal_pkg::WAY_W-1:0]      last_moved;
    sal_pkg::row_t                  row_new;

    logic                           mem_we;
    logic [sal_pkg::SET_W-1:0]      mem_waddr;
    sal_pkg::row_t                  mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= 5'd4;
            index_bits_reg  <= 4'd6;
            ways_in_use_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sal_pkg::REG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                sal_pkg::REG_INDEX_BITS:  index_bits_reg  <= cfg_data[3:0];
                sal_pkg::REG_WAYS_IN_USE: ways_in_use_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // set and tag split of the incoming address
    always_comb
    begin
        shifted   = address >> offset_bits_reg;
        tag_shift = {1'b0, offset_bits_reg} + {2'b00, index_bits_reg};
        imask     = (16'd1 << index_bits_reg) - 16'd1;
        set_in    = shifted[sal_pkg::SET_W-1:0] & imask[sal_pkg::SET_W-1:0];
        if (tag_shift >= 6'(sal_pkg::ADDR_WIDTH))
        begin
            tag_in = '0;
        end
        else
        begin
            tag_in = address >> tag_shift;
        end
    end

    // compare, then reorder the set: ways 1..last_moved take their younger neighbour
    always_comb
    begin
        if (ways_in_use_reg == 5'd0)
        begin
            ways_k = 5'd1;
        end
        else if (ways_in_use_reg > 5'(sal_pkg::MAX_WAYS))
        begin
            ways_k = 5'(sal_pkg::MAX_WAYS);
        end
        else
        begin
            ways_k = ways_in_use_reg;
        end
        pos = '0;
        for (int i = 0; i < sal_pkg::MAX_WAYS; i++)
        begin
            match[i] = (5'(i) < ways_k) && rdata_reg[i].valid && (rdata_reg[i].tag == tag_reg);
            if (match[i])
            begin
                pos = sal_pkg::WAY_W'(i);
            end
        end
        hit_now = |match;
        if (hit_now)
        begin
            last_moved = pos;
        end
        else
        begin
            last_moved = sal_pkg::WAY_W'(ways_k - 5'd1);
        end
        for (int i = 0; i < sal_pkg::MAX_WAYS; i++)
        begin
            if (i == 0)
            begin
                row_new[i] = hit_now ? rdata_reg[pos]
                                     : sal_pkg::way_t'{valid: 1'b1, tag: tag_reg};
            end
            else if (sal_pkg::WAY_W'(i) <= last_moved)
            begin
                row_new[i] = rdata_reg[i-1];
            end
            else
            begin
                row_new[i] = rdata_reg[i];
            end
        end
        row_new[0].valid = 1'b1;
    end

    always_comb
    begin
        mem_we    = cmd.update | cmd.clear_row;
        mem_waddr = cmd.clear_row ? sweep_reg : set_reg;
        mem_wdata = cmd.clear_row ? '0 : row_new;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.capture)
        begin
            rdata_reg <= mem[set_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            set_reg <= set_in;
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update | cmd.flush_done;
            if (cmd.clear_row)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.update)
            begin
                hit_reg <= hit_now;
                if (hit_now && (count_reg != '1))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (cmd.flush_done)
            begin
                hit_reg <= 1'b0;
            end
        end
    end

    assign status.sweep_last = &sweep_reg;
    assign done              = done_reg;
    assign hit               = hit_reg;
    assign hit_count         = count_reg;

endmodule

>>> test/tb_set_assoc_lru_cache_lookup.sv
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_lookup;

    localparam int IDLE_LIMIT = 20000;

    // tag-only LRU cache predictor; way 0 is most recent
    class lru_scoreboard;
        logic [31:0] tags [sal_pkg::MAX_SETS][sal_pkg::MAX_WAYS];
        bit          valids [sal_pkg::MAX_SETS][sal_pkg::MAX_WAYS];
        logic [31:0] hits_seen;
        int unsigned off_bits;
        int unsigned idx_bits;
        int unsigned ways;
        bit          exp_hit [$];
        logic [31:0] exp_count [$];
        int          mismatches;
        int          checked;

        function new();
            hits_seen = 0;
            off_bits = 4;
            idx_bits = 6;
            ways = 1;
            mismatches = 0;
            checked = 0;
            foreach (valids[s, w])
                valids[s][w] = 0;
        endfunction

        function void set_reg(logic [1:0] ri, logic [sal_pkg::CFG_W-1:0] val);
            if (ri == sal_pkg::REG_OFFSET_BITS)
                off_bits = val;
            else if (ri == sal_pkg::REG_INDEX_BITS)
                idx_bits = val[3:0];
            else if (ri == sal_pkg::REG_WAYS_IN_USE)
                ways = val;
        endfunction

        function void note_access(logic [2:0] kind, logic [31:0] addr);
            int unsigned set_i;
            int unsigned k;
            int unsigned pos;
            logic [63:0] shifted;
            logic [31:0] tag;
            logic [31:0] t;
            bit is_hit;
            is_hit = 0;
            pos = 0;
            if (kind == sal_pkg::ACC_FLUSH)
            begin
                foreach (valids[s, w])
                    valids[s][w] = 0;
            end
            else
            begin
                shifted = (off_bits >= 32) ? 64'd0 : ({32'd0, addr} >> off_bits);
                set_i = (shifted & ((64'd1 << idx_bits) - 1)) % sal_pkg::MAX_SETS;
                tag = (off_bits + idx_bits >= 32) ? 32'd0 : addr >> (off_bits + idx_bits);
                k = (ways == 0) ? 1 : (ways > sal_pkg::MAX_WAYS ? sal_pkg::MAX_WAYS : ways);
                for (int i = 0; i < k; i++)
                    if (valids[set_i][i] && tags[set_i][i] == tag)
                    begin
                        is_hit = 1;
                        pos = i;
                    end
                if (is_hit)
                begin
                    t = tags[set_i][pos];
                    for (int i = pos; i > 0; i--)
                    begin
                        tags[set_i][i] = tags[set_i][i-1];
                        valids[set_i][i] = valids[set_i][i-1];
                    end
                    tags[set_i][0] = t;
                    valids[set_i][0] = 1;
                    if (hits_seen != 32'hFFFF_FFFF)
                        hits_seen++;
                end
                else
                begin
                    for (int i = k - 1; i > 0; i--)
                    begin
                        tags[set_i][i] = tags[set_i][i-1];
                        valids[set_i][i] = valids[set_i][i-1];
                    end
                    tags[set_i][0] = tag;
                    valids[set_i][0] = 1;
                end
            end
            exp_hit.push_back(is_hit);
            exp_count.push_back(hits_seen);
        endfunction

        function void check_result(logic h, logic [31:0] cnt);
            bit eh;
            logic [31:0] ec;
            checked++;
            if (exp_hit.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit=%0b hit_count=%0d", h, cnt);
                return;
            end
            eh = exp_hit.pop_front();
            ec = exp_count.pop_front();
            if (h !== eh || cnt !== ec)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %0d: hit exp %0b got %0b, hit_count exp %0d got %0d",
                             checked, eh, h, ec, cnt);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [1:0]                cfg_index;
    logic [sal_pkg::CFG_W-1:0] cfg_data;
    logic                      start;
    logic                      busy;
    logic [2:0]                access_type;
    logic [31:0]               address;
    logic                      done;
    logic                      hit;
    logic [31:0]               hit_count;

    lru_scoreboard sb;
    int idle_cycles = 0;
    int accesses;
    int flushes;
    int hits_total;

    set_assoc_lru_cache_lookup uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .access_type(access_type),
        .address(address), .done(done), .hit(hit), .hit_count(hit_count)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(hit, hit_count);
            if (hit)
                hits_total++;
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired");
            $display("Simulation FAILED");
            $finish;
        end
    end

    // write enable drops for a cycle between writes
    task automatic write_reg(logic [1:0] ri, logic [sal_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= ri;
        cfg_data <= val;
        sb.set_reg(ri, val);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(4, 30));
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // one command transfer; start held until accepted, dropped by a gap or a drain
    task automatic send_access(logic [2:0] kind, logic [31:0] addr, bit gaps);
        if (gaps)
            random_gap();
        start <= 1'b1;
        access_type <= kind;
        address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_access(kind, addr);
        if (kind == sal_pkg::ACC_FLUSH)
            flushes++;
        else
            accesses++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.exp_hit.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // addresses drawn from a small pool of lines so that sets fill and hit
    task automatic random_phase(int n, int pool);
        logic [31:0] lines [];
        logic [31:0] a;
        logic [2:0]  k;
        lines = new[pool];
        foreach (lines[i])
            lines[i] = $urandom();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                a = lines[$urandom_range(0, pool - 1)] ^ $urandom_range(0, 15);
            else
                a = $urandom();
            k = ($urandom_range(0, 99) == 0) ? sal_pkg::ACC_FLUSH : 3'($urandom_range(0, 7));
            if (k == sal_pkg::ACC_FLUSH)
                k = ($urandom_range(0, 1)) ? sal_pkg::ACC_FLUSH : 3'd0;
            send_access(k, a, ($urandom_range(0, 3) != 0));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        access_type = '0;
        address = '0;
        accesses = 0;
        flushes = 0;
        hits_total = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, extreme addresses, every type, hits and evictions
        send_access(3'd0, 32'h0000_0000, 0);
        send_access(3'd1, 32'h0000_0000, 0);
        send_access(3'd2, 32'hFFFF_FFFF, 0);
        send_access(3'd3, 32'hFFFF_FFFF, 0);
        send_access(3'd5, 32'h0000_0400, 0);
        send_access(3'd6, 32'h0000_0000, 0);
        send_access(3'd7, 32'h0000_0400, 0);
        send_access(sal_pkg::ACC_FLUSH, 32'hFFFF_FFFF, 0);
        send_access(3'd0, 32'h0000_0400, 0);
        drain();

        // four ways: fill a set, reorder, evict the oldest
        write_reg(sal_pkg::REG_WAYS_IN_USE, 5'd4);
        for (int i = 0; i < 5; i++)
            send_access(3'd0, 32'h1000_0000 * i, 0);
        send_access(3'd1, 32'h1000_0000, 0);
        send_access(3'd2, 32'h4000_0000, 0);
        send_access(3'd0, 32'h0000_0000, 0);
        drain();

        // wide shifts: tag zero, then only address bit 31 left for the set index; ways 0 and out of range
        write_reg(sal_pkg::REG_OFFSET_BITS, 5'd20);
        write_reg(sal_pkg::REG_INDEX_BITS, 4'd12);
        write_reg(sal_pkg::REG_WAYS_IN_USE, 5'd0);
        send_access(3'd0, 32'hABCD_1234, 0);
        send_access(3'd0, 32'h1234_5678, 0);
        drain();
        write_reg(sal_pkg::REG_OFFSET_BITS, 5'd31);
        write_reg(sal_pkg::REG_WAYS_IN_USE, 5'd31);
        send_access(3'd0, 32'hFFFF_FFFF, 0);
        send_access(3'd3, 32'h0000_0001, 0);
        drain();

        // random phases across settings, extremes included
        random_phase(150, 12);
        drain();
        write_reg(sal_pkg::REG_OFFSET_BITS, 5'd0);
        write_reg(sal_pkg::REG_INDEX_BITS, 4'd0);
        write_reg(sal_pkg::REG_WAYS_IN_USE, 5'd16);
        random_phase(200, 24);
        drain();
        write_reg(sal_pkg::REG_OFFSET_BITS, 5'd16);
        write_reg(sal_pkg::REG_INDEX_BITS, 4'd15);
        write_reg(sal_pkg::REG_WAYS_IN_USE, 5'd2);
        random_phase(150, 40);
        drain();
        // narrow change may leave duplicate tags in a set
        write_reg(sal_pkg::REG_INDEX_BITS, 4'd1);
        write_reg(sal_pkg::REG_WAYS_IN_USE, 5'd8);
        random_phase(200, 20);
        drain();
        write_reg(sal_pkg::REG_OFFSET_BITS, 5'd4);
        write_reg(sal_pkg::REG_INDEX_BITS, 4'd3);
        write_reg(sal_pkg::REG_WAYS_IN_USE, 5'd1);
        random_phase(150, 10);
        drain();
        for (int j = 0; j < 4; j++)
        begin
            write_reg(sal_pkg::REG_OFFSET_BITS, 5'($urandom_range(0, 31)));
            write_reg(sal_pkg::REG_INDEX_BITS, 4'($urandom_range(0, 15)));
            write_reg(sal_pkg::REG_WAYS_IN_USE, 5'($urandom_range(0, 31)));
            random_phase(100, $urandom_range(4, 30));
            drain();
        end

        $display("covered %0d lookups and %0d flushes, %0d hits, over several geometries",
                 accesses, flushes, hits_total);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
